FILE: src/imuoc_pkg.sv
// ----------------------------------------------------------------------------
// imuoc_pkg
// Shared widths, constants and arithmetic helpers for the IMU offset
// calibration and moving-average core.
// ----------------------------------------------------------------------------
`default_nettype none

package imuoc_pkg;

    // Sample format and block sizes
    localparam int SAMPLE_W    = 16;
    localparam int AXES        = 6;
    localparam int CAL_SAMPLES = 50;
    localparam int WINDOW_LEN  = 10;
    localparam int ONE_G_W     = 15;

    localparam logic [ONE_G_W-1:0] ONE_G_RESET = ONE_G_W'(65536 / 16);

    // Running window sum and its truncated mean
    localparam int WSUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int MEAN_W      = SAMPLE_W + 1;
    localparam int WIN_SHIFT   = WSUM_W + $clog2(WINDOW_LEN);
    localparam int WIN_RECIP_W = WIN_SHIFT + 1;
    localparam logic [WIN_RECIP_W-1:0] WIN_RECIP =
        WIN_RECIP_W'(((64'd1 << WIN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // Calibration sums, bias and the gyro numerator
    localparam int CSUM_W      = SAMPLE_W + 1 + $clog2(CAL_SAMPLES);
    localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
    localparam int BIAS_W      = SAMPLE_W + 1;
    localparam int NUM_W       = SAMPLE_W + 2 + $clog2(CAL_SAMPLES);
    localparam int CAL_SHIFT   = NUM_W + $clog2(CAL_SAMPLES);
    localparam int CAL_RECIP_W = CAL_SHIFT + 1;
    localparam logic [CAL_RECIP_W-1:0] CAL_RECIP =
        CAL_RECIP_W'(((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic signed [NUM_W-1:0] CAL_SAMPLES_S = NUM_W'(CAL_SAMPLES);

    // Output saturation limits
    localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [NUM_W-1:0] SAT_LO = NUM_W'(-(2 ** (SAMPLE_W - 1)));

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WSUM_W-1:0]   t_wsum;
    typedef logic signed [CSUM_W-1:0]   t_csum;
    typedef logic signed [MEAN_W-1:0]   t_mean;
    typedef logic signed [BIAS_W-1:0]   t_bias;
    typedef logic signed [NUM_W-1:0]    t_num;

    // Window sum divided by the window length, truncated toward zero
    function automatic t_mean win_mean(input t_wsum s);
        logic [WSUM_W-1:0]             mag;
        logic [WSUM_W+WIN_RECIP_W-1:0] prod;
        logic [MEAN_W-1:0]             q;
        mag  = s[WSUM_W-1] ? WSUM_W'(-s) : WSUM_W'(s);
        prod = (WSUM_W + WIN_RECIP_W)'(mag) * (WSUM_W + WIN_RECIP_W)'(WIN_RECIP);
        q    = MEAN_W'(prod >> WIN_SHIFT);
        return s[WSUM_W-1] ? t_mean'(-q) : t_mean'(q);
    endfunction

    // Value divided by the calibration length, truncated toward zero
    function automatic t_num cal_div(input t_num s);
        logic [NUM_W-1:0]             mag;
        logic [NUM_W+CAL_RECIP_W-1:0] prod;
        logic [NUM_W-1:0]             q;
        mag  = s[NUM_W-1] ? NUM_W'(-s) : NUM_W'(s);
        prod = (NUM_W + CAL_RECIP_W)'(mag) * (NUM_W + CAL_RECIP_W)'(CAL_RECIP);
        q    = NUM_W'(prod >> CAL_SHIFT);
        return s[NUM_W-1] ? t_num'(-q) : t_num'(q);
    endfunction

    // Clamp to the signed sample range
    function automatic t_sample sat16(input t_num v);
        t_num c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return t_sample'(c[SAMPLE_W-1:0]);
    endfunction

endpackage

`default_nettype wire

FILE: src/imu_offset_cal_moving_average_core.sv
// ----------------------------------------------------------------------------
// imu_offset_cal_moving_average_core
// Six-axis IMU filter: bias calibration over the first samples after reset,
// then a per-axis moving average less the bias, saturated to 16 bits.
//
// Channel   Handshake             Payload
// input     i_valid / o_ready     i_accel_x/y/z, i_gyro_x/y/z
// output    o_valid / i_ready     o_filt_accel_x/y/z, o_filt_gyro_x/y/z, o_calibrated
// config    i_cfg_wr_en           i_cfg_wr_data (one g count)
//
// One request per cycle while o_ready is high; o_valid rises through four
// register stages: state update (loaded at accept), window mean divide,
// bias subtract, gyro bias divide.
// Reset is synchronous and clears the window and calibration at once.
// A stage takes a new request whenever it is empty or its request moves on;
// o_ready falls only when all four stages hold requests and i_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_offset_cal_moving_average_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // sample channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire imuoc_pkg::t_sample             i_accel_x,
    input  wire imuoc_pkg::t_sample             i_accel_y,
    input  wire imuoc_pkg::t_sample             i_accel_z,
    input  wire imuoc_pkg::t_sample             i_gyro_x,
    input  wire imuoc_pkg::t_sample             i_gyro_y,
    input  wire imuoc_pkg::t_sample             i_gyro_z,
    // configuration
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [imuoc_pkg::ONE_G_W-1:0]  i_cfg_wr_data,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output imuoc_pkg::t_sample                  o_filt_accel_x,
    output imuoc_pkg::t_sample                  o_filt_accel_y,
    output imuoc_pkg::t_sample                  o_filt_accel_z,
    output imuoc_pkg::t_sample                  o_filt_gyro_x,
    output imuoc_pkg::t_sample                  o_filt_gyro_y,
    output imuoc_pkg::t_sample                  o_filt_gyro_z,
    output logic                                o_calibrated
);
    import imuoc_pkg::*;

    // Stage valids and advance enables
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vo;
    logic adv1;
    logic adv2;
    logic adv3;
    logic advo;
    logic accept;

    logic [ONE_G_W-1:0] r_one_g;

    t_sample sample [AXES];
    t_wsum   wsum   [AXES];
    t_csum   csum   [AXES];
    logic    cal_done;

    // Stage 2: window means and bias terms
    t_mean r2_mean [AXES];
    t_bias r2_bias [3];
    t_csum r2_gsum [3];
    logic  r2_done;
    t_bias n2_bias [3];
    t_num  quot    [3];

    // Stage 3: accel results and gyro numerators
    t_sample r3_acc [3];
    t_num    r3_num [3];
    logic    r3_done;

    // Output register
    t_sample r_out_acc  [3];
    t_sample r_out_gyro [3];
    logic    r_out_done;

    // Move a stage forward when it is empty or the next one moves
    assign advo    = !r_vo || i_ready;
    assign adv3    = !r_v3 || advo;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign accept  = i_valid && adv1;

    assign sample[0] = i_accel_x;
    assign sample[1] = i_accel_y;
    assign sample[2] = i_accel_z;
    assign sample[3] = i_gyro_x;
    assign sample[4] = i_gyro_y;
    assign sample[5] = i_gyro_z;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_g <= ONE_G_RESET;
        end else if (i_cfg_wr_en) begin
            r_one_g <= i_cfg_wr_data;
        end
    end

    // Stage 1: window and calibration state, updated on accept
    imuoc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_sample (sample),
        .o_wsum   (wsum)
    );

    imuoc_cal u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_sample (sample),
        .i_one_g  (r_one_g),
        .o_sum    (csum),
        .o_done   (cal_done)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (advo) begin
                r_vo <= r_v3;
            end
        end
    end

    // Accel bias: frozen calibration sum over the sample count
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            quot[a]    = cal_div(NUM_W'(csum[a]));
            n2_bias[a] = cal_done ? quot[a][BIAS_W-1:0] : '0;
        end
    end

    // Stage 2: divide window sums, pick up the bias terms
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            for (int a = 0; a < AXES; a++) begin
                r2_mean[a] <= win_mean(wsum[a]);
            end
            for (int a = 0; a < 3; a++) begin
                r2_bias[a] <= n2_bias[a];
                r2_gsum[a] <= cal_done ? csum[3+a] : '0;
            end
            r2_done <= cal_done;
        end
    end

    // Stage 3: accel mean less bias; gyro scaled mean less bias sum
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            for (int a = 0; a < 3; a++) begin
                r3_acc[a] <= sat16(NUM_W'(r2_mean[a]) - NUM_W'(r2_bias[a]));
                r3_num[a] <= NUM_W'(r2_mean[3+a]) * CAL_SAMPLES_S - NUM_W'(r2_gsum[a]);
            end
            r3_done <= r2_done;
        end
    end

    // Output register: gyro divide and saturate
    always_ff @(posedge i_clk) begin
        if (advo) begin
            for (int a = 0; a < 3; a++) begin
                r_out_acc[a]  <= r3_acc[a];
                r_out_gyro[a] <= sat16(cal_div(r3_num[a]));
            end
            r_out_done <= r3_done;
        end
    end

    assign o_valid        = r_vo;
    assign o_filt_accel_x = r_out_acc[0];
    assign o_filt_accel_y = r_out_acc[1];
    assign o_filt_accel_z = r_out_acc[2];
    assign o_filt_gyro_x  = r_out_gyro[0];
    assign o_filt_gyro_y  = r_out_gyro[1];
    assign o_filt_gyro_z  = r_out_gyro[2];
    assign o_calibrated   = r_out_done;

    // Once a calibrated result is shown, every later result is calibrated
    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_calibrated |=> o_calibrated)
        else $error("calibrated flag dropped after calibration");

    // Input stalls only when every stage holds a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && r_vo && !i_ready)
        else $error("input stalled with a free stage");

    // Before calibration ends no bias reaches stage 2; checks accel x/z bias and gyro x sum
    a_no_early_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r2_done |-> r2_bias[0] == '0 && r2_bias[2] == '0 && r2_gsum[0] == '0)
        else $error("bias applied before calibration finished");

endmodule

`default_nettype wire

FILE: src/imuoc_window.sv
// ----------------------------------------------------------------------------
// imuoc_window
// Per-axis shift line of the last samples with a running window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module imuoc_window (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire imuoc_pkg::t_sample   i_sample [imuoc_pkg::AXES],
    output imuoc_pkg::t_wsum          o_wsum   [imuoc_pkg::AXES]
);
    import imuoc_pkg::*;

    t_sample r_tap [AXES][WINDOW_LEN];
    t_wsum   r_sum [AXES];

    // Shift in the new sample, drop the oldest, keep the sum in step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
                for (int k = 0; k < WINDOW_LEN; k++) begin
                    r_tap[a][k] <= '0;
                end
            end
        end else if (i_en) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a]    <= r_sum[a] + WSUM_W'(i_sample[a])
                               - WSUM_W'(r_tap[a][WINDOW_LEN-1]);
                r_tap[a][0] <= i_sample[a];
                for (int k = 1; k < WINDOW_LEN; k++) begin
                    r_tap[a][k] <= r_tap[a][k-1];
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_wsum[a] = r_sum[a];
        end
    end

endmodule

`default_nettype wire

FILE: src/imuoc_cal.sv
// ----------------------------------------------------------------------------
// imuoc_cal
// Calibration accumulators: sums the first samples after reset per axis,
// then freezes the sums for use as bias.
// ----------------------------------------------------------------------------
`default_nettype none

module imuoc_cal (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire imuoc_pkg::t_sample              i_sample [imuoc_pkg::AXES],
    input  wire logic [imuoc_pkg::ONE_G_W-1:0]   i_one_g,
    output imuoc_pkg::t_csum                     o_sum    [imuoc_pkg::AXES],
    output logic                                 o_done
);
    import imuoc_pkg::*;

    logic             r_active;
    logic             n_active;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_csum            r_sum [AXES];
    t_csum            n_sum [AXES];
    t_csum            one_g;

    assign one_g = t_csum'({1'b0, i_one_g});

    // Accumulate while calibrating; z accel has one g taken off
    always_comb begin
        n_active = r_active;
        n_count  = r_count;
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a];
        end
        if (i_en && r_active) begin
            n_count = r_count + 1'b1;
            for (int a = 0; a < AXES; a++) begin
                n_sum[a] = r_sum[a] + CSUM_W'(i_sample[a]);
            end
            n_sum[2] = r_sum[2] + CSUM_W'(i_sample[2]) - one_g;
            if (r_count == CNT_W'(CAL_SAMPLES - 1)) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_count  <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= n_sum[a];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_sum[a] = r_sum[a];
        end
    end

    assign o_done = !r_active;

endmodule

`default_nettype wire
